>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication in the same cycle
`define HRKE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle
`define HRKE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HRKE_ASSERT_SAME(label, ante, cons, msg)
`define HRKE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> sv/hrke_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrke_pkg
// Types, codes and constants shared by the key edge event block.
// ---------------------------------------------------------------------------
package hrke_pkg;

	localparam int NUM_MAP_REGS = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int CODE_W       = 16;
	localparam int CFG_DATA_W   = 64;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LAST  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_ID = 3'd6;

	// Report byte positions that are kept
	localparam int POS_ID  = 0;
	localparam int POS_B9  = 9;
	localparam int POS_B13 = 13;
	localparam int POS_B16 = 16;
	localparam int POS_B17 = 17;
	localparam int POS_B18 = 18;

	localparam logic [7:0] LOW_NIBBLE  = 8'h0f;
	localparam logic [7:0] HIGH_NIBBLE = 8'hf0;
	localparam logic [7:0] RESET_ID    = 8'h03;

	typedef logic [NUM_MAP_REGS-1:0][CFG_DATA_W-1:0] map_regs_t;

	localparam map_regs_t MAP_RESET = {
		64'd54606974423138495, 64'd53481057336164539, 64'd52355140249190583,
		64'd24770171617148995, 64'd18577627639971903, 64'd17451710552997947
	};

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_SYNC    = 2'd2
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PACK,
		ST_SCAN,
		ST_SYNC
	} scan_state_t;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] b9;
		logic [7:0] b13;
		logic [7:0] b16;
		logic [7:0] b17;
		logic [7:0] b18;
	} capture_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} byte_xfer_t;

	// Overlapping OR and shift layout of the key state; caller masks the width
	function automatic logic [31:0] pack_keys(capture_t c);
		logic [31:0] r;
		r = {24'd0, c.b16}
			| ({24'd0, c.b17 & LOW_NIBBLE} << 8)
			| ({24'd0, c.b18} << 10)
			| ({24'd0, c.b9} << 11)
			| ({24'd0, c.b13} << 19)
			| ({24'd0, c.b17 & HIGH_NIBBLE} << 16);
		return r;
	endfunction

endpackage

>>> sv/hrke_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrke channel interfaces
// Valid/ready channels for report bytes in and key events out.
// ---------------------------------------------------------------------------
interface hrke_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       end_of_report;

	modport source (output valid, output report_byte, output end_of_report, input ready);
	modport sink   (input valid, input report_byte, input end_of_report, output ready);
endinterface

interface hrke_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] key_code;
	logic        last_event;

	modport source (output valid, output event_kind, output key_code, output last_event,
		input ready);
	modport sink   (input valid, input event_kind, input key_code, input last_event,
		output ready);
endinterface

>>> sv/hid_report_key_edge_events.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hid_report_key_edge_events
// Collects a byte-serial input report and emits key press/release events
// for changed key bits, closed by a sync event.
// ---------------------------------------------------------------------------
//  channel   dir  payload                               transfer when
//  in_ch     in   report_byte, end_of_report            valid && ready
//  out_ch    out  event_kind, key_code, last_event      valid && ready
//  cfg       in   cfg_index, cfg_wr_data                cfg_wr_en
//
//  A report byte without end mark is taken while idle. A final byte takes a
//  packing step, then the scanner steps one bit a cycle up to the highest
//  changed bit and stops once no changed bit is left, then the sync step;
//  a report with another id skips the scan. Output stalls hold the scanner
//  on the current event; in_ch.ready is low from the final byte until the
//  sync event is loaded. Reset state is idle.
// ---------------------------------------------------------------------------
module hid_report_key_edge_events #(
	parameter int KEY_BITS         = 24,
	parameter int MAX_REPORT_BYTES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [hrke_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrke_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	hrke_in_if.sink                          in_ch,
	hrke_out_if.source                       out_ch
);

	`include "assert_macros.svh"

	hrke_pkg::map_regs_t  map_q;
	logic [7:0]           wanted_id_q;
	hrke_pkg::byte_xfer_t xfer;
	hrke_pkg::capture_t   cap;
	logic                 scan_ready;
	logic                 in_xfer;

	assign in_xfer    = in_ch.valid && scan_ready;
	assign in_ch.ready = scan_ready;

	assign xfer.valid = in_xfer;
	assign xfer.data  = in_ch.report_byte;
	assign xfer.last  = in_ch.end_of_report;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= hrke_pkg::MAP_RESET;
			wanted_id_q <= hrke_pkg::RESET_ID;
		end else if (cfg_wr_en) begin
			if (cfg_index <= hrke_pkg::CFG_MAP_LAST)
				map_q[cfg_index] <= cfg_wr_data;
			else if (cfg_index == hrke_pkg::CFG_WANTED_ID)
				wanted_id_q <= cfg_wr_data[7:0];
		end
	end

	hrke_capture #(
		.MAX_REPORT_BYTES (MAX_REPORT_BYTES)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.xfer   (xfer),
		.cap    (cap)
	);

	hrke_scan #(
		.KEY_BITS (KEY_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer && in_ch.end_of_report),
		.cap       (cap),
		.wanted_id (wanted_id_q),
		.map_regs  (map_q),
		.ready     (scan_ready),
		.ev_valid  (out_ch.valid),
		.ev_ready  (out_ch.ready),
		.ev_kind   (out_ch.event_kind),
		.ev_code   (out_ch.key_code),
		.ev_last   (out_ch.last_event)
	);

	// a final byte always leaves the block busy, in the packing state at least
	`HRKE_ASSERT_NEXT(a_busy_after_end, in_xfer && in_ch.end_of_report, !in_ch.ready, "ready after final byte")
	// the closing event is a sync with a zero code
	`HRKE_ASSERT_SAME(a_last_is_sync, out_ch.valid && out_ch.last_event, out_ch.event_kind == hrke_pkg::KIND_SYNC && out_ch.key_code == '0, "last event is not a clean sync")
	// key events never carry the last mark
	`HRKE_ASSERT_SAME(a_key_not_last, out_ch.valid && out_ch.event_kind != hrke_pkg::KIND_SYNC, !out_ch.last_event, "key event marked last")

endmodule

>>> sv/hrke_capture.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrke_capture
// Tracks the byte position in a report and keeps the id and key bytes.
// ---------------------------------------------------------------------------
module hrke_capture #(
	parameter int MAX_REPORT_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hrke_pkg::byte_xfer_t xfer,
	output hrke_pkg::capture_t   cap
);

	localparam int POS_W = $clog2(MAX_REPORT_BYTES + 1);

	logic [POS_W-1:0]   pos_q;
	hrke_pkg::capture_t cap_q;
	logic               first;
	logic               in_range;

	assign first    = (pos_q == '0);
	assign in_range = (pos_q < POS_W'(MAX_REPORT_BYTES));
	assign cap      = cap_q;

	function automatic logic [7:0] next_slot(logic [7:0] old, logic hit, logic clr,
		logic [7:0] data);
		logic [7:0] r;
		r = old;
		if (hit)
			r = data;
		else if (clr)
			r = '0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cap_q <= '0;
		end else if (xfer.valid) begin
			// first byte of a report wipes the slots, bytes past the limit are dropped
			cap_q.id  <= next_slot(cap_q.id,  in_range && pos_q == POS_W'(hrke_pkg::POS_ID),
				first, xfer.data);
			cap_q.b9  <= next_slot(cap_q.b9,  in_range && pos_q == POS_W'(hrke_pkg::POS_B9),
				first, xfer.data);
			cap_q.b13 <= next_slot(cap_q.b13, in_range && pos_q == POS_W'(hrke_pkg::POS_B13),
				first, xfer.data);
			cap_q.b16 <= next_slot(cap_q.b16, in_range && pos_q == POS_W'(hrke_pkg::POS_B16),
				first, xfer.data);
			cap_q.b17 <= next_slot(cap_q.b17, in_range && pos_q == POS_W'(hrke_pkg::POS_B17),
				first, xfer.data);
			cap_q.b18 <= next_slot(cap_q.b18, in_range && pos_q == POS_W'(hrke_pkg::POS_B18),
				first, xfer.data);
			if (xfer.last)
				pos_q <= '0;
			else if (in_range)
				pos_q <= pos_q + 1'b1;
		end
	end

endmodule

>>> sv/hrke_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrke_scan
// Packs the key state and walks the key bits one per cycle, held while the
// output stalls, with a shifting mask, loading press/release events for changed bits and a closing sync event.
// ---------------------------------------------------------------------------
module hrke_scan #(
	parameter int KEY_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hrke_pkg::capture_t   cap,
	input  logic [7:0]           wanted_id,
	input  hrke_pkg::map_regs_t  map_regs,
	output logic                 ready,
	output logic                 ev_valid,
	input  logic                 ev_ready,
	output logic [1:0]           ev_kind,
	output logic [15:0]          ev_code,
	output logic                 ev_last
);

	localparam int IDX_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	hrke_pkg::scan_state_t state_q, state_d;

	logic [KEY_BITS-1:0] key_state_q;
	logic [KEY_BITS-1:0] mask_sh_q;
	logic [KEY_BITS-1:0] state_sh_q;
	logic [IDX_W-1:0]    idx_q;
	logic [KEY_BITS-1:0] packed_keys;
	logic [31:0]         packed_full;
	logic [4:0]          bit_ext;
	logic [15:0]         code_sel;
	logic                id_match;
	logic                out_free;
	logic                do_pack;
	logic                do_shift;
	logic                load_ev;
	logic                load_sync;

	logic                  valid_q;
	hrke_pkg::event_kind_t kind_q;
	logic [15:0]           code_q;
	logic                  last_q;

	assign packed_full = hrke_pkg::pack_keys(cap);
	assign packed_keys = packed_full[KEY_BITS-1:0];
	assign id_match    = (cap.id == wanted_id);
	assign out_free    = !valid_q || ev_ready;
	assign bit_ext     = 5'(idx_q);
	assign code_sel    = map_regs[bit_ext[4:2]][{bit_ext[1:0], 4'd0} +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hrke_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ready     = 1'b0;
		do_pack   = 1'b0;
		do_shift  = 1'b0;
		load_ev   = 1'b0;
		load_sync = 1'b0;
		unique case (state_q)
			hrke_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start)
					state_d = hrke_pkg::ST_PACK;
			end
			hrke_pkg::ST_PACK: begin
				do_pack = 1'b1;
				state_d = id_match ? hrke_pkg::ST_SCAN : hrke_pkg::ST_SYNC;
			end
			hrke_pkg::ST_SCAN: begin
				// stop as soon as no changed bit is left
				if (mask_sh_q == '0)
					state_d = hrke_pkg::ST_SYNC;
				else if (mask_sh_q[0]) begin
					if (out_free) begin
						load_ev  = 1'b1;
						do_shift = 1'b1;
					end
				end else
					do_shift = 1'b1;
			end
			hrke_pkg::ST_SYNC: begin
				if (out_free) begin
					load_sync = 1'b1;
					state_d   = hrke_pkg::ST_IDLE;
				end
			end
			default: state_d = hrke_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_state_q <= '0;
			mask_sh_q   <= '0;
			state_sh_q  <= '0;
			idx_q       <= '0;
		end else if (do_pack) begin
			idx_q <= '0;
			if (id_match) begin
				key_state_q <= packed_keys;
				mask_sh_q   <= packed_keys ^ key_state_q;
				state_sh_q  <= packed_keys;
			end else
				mask_sh_q <= '0;
		end else if (do_shift) begin
			mask_sh_q  <= mask_sh_q >> 1;
			state_sh_q <= state_sh_q >> 1;
			idx_q      <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load_ev || load_sync)
			valid_q <= 1'b1;
		else if (ev_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_ev) begin
			kind_q <= state_sh_q[0] ? hrke_pkg::KIND_PRESS : hrke_pkg::KIND_RELEASE;
			code_q <= code_sel;
			last_q <= 1'b0;
		end else if (load_sync) begin
			kind_q <= hrke_pkg::KIND_SYNC;
			code_q <= '0;
			last_q <= 1'b1;
		end
	end

	assign ev_valid = valid_q;
	assign ev_kind  = kind_q;
	assign ev_code  = code_q;
	assign ev_last  = last_q;

endmodule
